FILE: rtl/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// Shared constants, types and helpers for the linear blend skinning core.
// ----------------------------------------------------------------------------
`default_nettype none

package lbvs_pkg;

    localparam int BONE_COUNT     = 64;
    localparam int MAX_INFLUENCES = 4;
    localparam int ROW_ELEMS      = 4;
    localparam int BONE_ELEMS     = 12;
    localparam int PALETTE_SIZE   = BONE_COUNT * BONE_ELEMS;
    localparam int IDX_W          = 6;
    localparam int WGT_W          = 16;
    localparam int ENTRY_W        = 10;
    localparam int ELEM_W         = $clog2(BONE_ELEMS);
    localparam int BONE_W         = $clog2(BONE_COUNT);
    localparam int SUM_W          = 51;

    localparam logic [WGT_W-1:0] WEIGHT_ONE = 16'd32768;

    // operation codes
    localparam logic OP_SKIN  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // one bone: rows 0..2 of the matrix, element e = row*4 + column
    typedef logic [BONE_ELEMS-1:0][31:0] t_bone;
    typedef logic signed [SUM_W-1:0]     t_sum;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input t_sum v);
        logic signed [31:0] r;
        if (v > t_sum'(32'sh7fff_ffff)) begin
            r = 32'sh7fff_ffff;
        end else if (v < t_sum'(-(64'sh8000_0000))) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lbvs_in_if.sv
// ----------------------------------------------------------------------------
// lbvs_in_if
// Input channel: vertex items and palette write items.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbvs_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic signed [31:0] vertex_z;
    logic [23:0]        bone_indices;
    logic [63:0]        bone_weights;
    logic [9:0]         palette_entry;
    logic signed [31:0] palette_value;

    modport source (output valid, operation, vertex_x, vertex_y, vertex_z, bone_indices,
                    bone_weights, palette_entry, palette_value, input ready);
    modport sink   (input valid, operation, vertex_x, vertex_y, vertex_z, bone_indices,
                    bone_weights, palette_entry, palette_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/lbvs_out_if.sv
// ----------------------------------------------------------------------------
// lbvs_out_if
// Output channel: skinned positions.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbvs_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] skinned_x;
    logic signed [31:0] skinned_y;
    logic signed [31:0] skinned_z;

    modport source (output valid, skinned_x, skinned_y, skinned_z, input ready);
    modport sink   (input valid, skinned_x, skinned_y, skinned_z, output ready);
endinterface

`default_nettype wire

FILE: rtl/linear_blend_vertex_skinning_core.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_core
// Four-influence linear blend skinning of Q16.16 positions.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless stalled, vertex or palette write alike, and
// returns one skinned position per vertex through stages A to G. The bone
// palette lives in four bone-wide synchronous memories, one per influence
// slot, so the four bones of a vertex are read in its transfer cycle; a
// palette write lands on the same edge it is taken, so the very next vertex
// sees it. Each pipeline stage holds while the one after it is full and
// stalled, so bubbles collapse and input keeps flowing while a result waits.
// The palette is undefined after reset: load every bone before using it.
`default_nettype none

module linear_blend_vertex_skinning_core (
    input  wire  i_clk,
    input  wire  i_rst_n,
    lbvs_in_if.sink    i_in,
    lbvs_out_if.source o_out
);
    import lbvs_pkg::*;

    localparam int NS = MAX_INFLUENCES;
    localparam t_sum RND15 = t_sum'(64'sd16384);
    localparam logic signed [63:0] RND16 = 64'sd32768;

    // stage valids and advance enables
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg;
    logic en_a, en_b, en_c, en_d, en_e, en_f, en_g;

    assign en_g = !r_vg || o_out.ready;
    assign en_f = !r_vf || en_g;
    assign en_e = !r_ve || en_f;
    assign en_d = !r_vd || en_e;
    assign en_c = !r_vc || en_d;
    assign en_b = !r_vb || en_c;
    assign en_a = !r_va || en_b;

    assign i_in.ready = en_a;

    logic xfer;
    assign xfer = i_in.valid && en_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0; r_vb <= 1'b0; r_vc <= 1'b0; r_vd <= 1'b0;
            r_ve <= 1'b0; r_vf <= 1'b0; r_vg <= 1'b0;
        end else begin
            if (en_a) r_va <= xfer && (i_in.operation == OP_SKIN);
            if (en_b) r_vb <= r_va;
            if (en_c) r_vc <= r_vb;
            if (en_d) r_vd <= r_vc;
            if (en_e) r_ve <= r_vd;
            if (en_f) r_vf <= r_ve;
            if (en_g) r_vg <= r_vf;
        end
    end

    // palette write decode: bone = entry / 12 via reciprocal, element = rest
    logic [ENTRY_W+9:0] wb_prod;
    logic [BONE_W-1:0]  wr_bone;
    logic [ELEM_W-1:0]  wr_elem;
    logic               wr_en;

    always_comb begin
        wb_prod = (ENTRY_W+10)'(i_in.palette_entry) * (ENTRY_W+10)'(683);
        wr_bone = wb_prod[13 +: BONE_W];
        wr_elem = ELEM_W'(i_in.palette_entry - ENTRY_W'(wr_bone) * ENTRY_W'(BONE_ELEMS));
        wr_en   = xfer && (i_in.operation == OP_WRITE)
                  && (i_in.palette_entry < ENTRY_W'(PALETTE_SIZE));
    end

    // slot decode: clamp weight, drop out-of-range bones
    logic [NS-1:0][BONE_W-1:0] rd_bone;
    logic [NS-1:0][WGT_W-1:0]  wgt;
    logic [NS-1:0]             live;

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            logic [IDX_W-1:0] idx;
            logic [WGT_W-1:0] w;
            idx = i_in.bone_indices[IDX_W*s +: IDX_W];
            w   = i_in.bone_weights[WGT_W*s +: WGT_W];
            if (w > WEIGHT_ONE) w = WEIGHT_ONE;
            live[s]    = (w != '0) && ((IDX_W+1)'(idx) < (IDX_W+1)'(BONE_COUNT));
            wgt[s]     = live[s] ? w : '0;
            rd_bone[s] = idx[BONE_W-1:0];
        end
    end

    // palette memories, one copy per slot
    t_bone r_pal [NS][BONE_COUNT];
    t_bone r_rd  [NS];

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            if (wr_en) r_pal[s][wr_bone][wr_elem] <= i_in.palette_value;
            if (en_a)  r_rd[s] <= r_pal[s][rd_bone[s]];
        end
    end

    // stage A: vertex payload
    logic signed [2:0][31:0] r_pos_a, r_pos_b, r_pos_c, r_pos_d, r_pos_e, r_pos_f;
    logic [NS-1:0][WGT_W-1:0] r_w_a;
    logic r_any_a, r_any_b, r_any_c, r_any_d, r_any_e, r_any_f;

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_pos_a <= {i_in.vertex_z, i_in.vertex_y, i_in.vertex_x};
            r_w_a   <= wgt;
            r_any_a <= |live;
        end
    end

    // stage B: weight times bone element
    logic signed [48:0] r_pb [NS][BONE_ELEMS];

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            for (int s = 0; s < NS; s++) begin
                for (int e = 0; e < BONE_ELEMS; e++) begin
                    r_pb[s][e] <= $signed({1'b0, r_w_a[s]}) * $signed(r_rd[s][e]);
                end
            end
            r_pos_b <= r_pos_a;
            r_any_b <= r_any_a;
        end
    end

    // stage C: blend the slots, add rounding half
    t_sum r_sc [BONE_ELEMS];

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            for (int e = 0; e < BONE_ELEMS; e++) begin
                t_sum acc;
                acc = RND15;
                for (int s = 0; s < NS; s++) acc = acc + t_sum'(r_pb[s][e]);
                r_sc[e] <= acc;
            end
            r_pos_c <= r_pos_b;
            r_any_c <= r_any_b;
        end
    end

    // stage D: blended matrix element, Q16.16 saturated
    logic signed [31:0] r_m [BONE_ELEMS];

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            for (int e = 0; e < BONE_ELEMS; e++) r_m[e] <= sat32(r_sc[e] >>> 15);
            r_pos_d <= r_pos_c;
            r_any_d <= r_any_c;
        end
    end

    // stage E: matrix times position (element select of a packed array is unsigned)
    logic signed [63:0] r_pe [3][3];
    logic signed [31:0] r_t  [3];

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pe[r][c] <= r_m[r*ROW_ELEMS + c] * $signed(r_pos_d[c]);
                end
                r_t[r] <= r_m[r*ROW_ELEMS + 3];
            end
            r_pos_e <= r_pos_d;
            r_any_e <= r_any_d;
        end
    end

    // stage F: rounded row sums plus translation
    t_sum r_sf [3];

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            for (int r = 0; r < 3; r++) begin
                t_sum acc;
                logic signed [63:0] rp;
                acc = t_sum'(r_t[r]);
                for (int c = 0; c < 3; c++) begin
                    rp  = (r_pe[r][c] + RND16) >>> 16;
                    acc = acc + rp[SUM_W-1:0];
                end
                r_sf[r] <= acc;
            end
            r_pos_f <= r_pos_e;
            r_any_f <= r_any_e;
        end
    end

    // stage G: output register, pass-through when no bone contributes
    logic signed [2:0][31:0] r_res;

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            for (int r = 0; r < 3; r++) begin
                r_res[r] <= r_any_f ? sat32(r_sf[r]) : r_pos_f[r];
            end
        end
    end

    assign o_out.valid     = r_vg;
    assign o_out.skinned_x = r_res[0];
    assign o_out.skinned_y = r_res[1];
    assign o_out.skinned_z = r_res[2];

endmodule

`default_nettype wire
